@@ hw/rtl/chm_pkg.sv @@
// Shared types and constants for the chained hash map.
package chm_pkg;

  localparam logic [31:0] GOLDEN_Q32 = 32'd2654435769;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic CFG_HASH_MODE    = 1'b0;
  localparam logic CFG_INIT_BUCKETS = 1'b1;

  localparam logic HASH_MULT = 1'b0;
  localparam logic HASH_MOD  = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [30:0]        key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] value_out;
    logic               status;
    logic [8:0]         entry_count;
    logic [8:0]         bucket_count;
  } out_item_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MUL1,
    HS_MUL2,
    HS_DIV
  } hash_st_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HSTART,
    ST_HWAIT,
    ST_TAKEHEAD,
    ST_WALK,
    ST_CMP,
    ST_TAKEVAL,
    ST_POP,
    ST_RSCHK,
    ST_RCLR,
    ST_RBKT,
    ST_RTAKE,
    ST_RNODE,
    ST_RKEY,
    ST_RHW,
    ST_RRELINK,
    ST_RCPR,
    ST_RCPW,
    ST_FIN
  } ctrl_st_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_HASH_ITEM,
    OP_RD_HEAD,
    OP_TAKE_HEAD,
    OP_RD_NODE,
    OP_STEP,
    OP_UPDATE,
    OP_RD_VAL,
    OP_TAKE_VAL,
    OP_UNLINK,
    OP_FULL,
    OP_RD_FREE,
    OP_ALLOC,
    OP_GROW,
    OP_SHRINK,
    OP_CLR_SPARE,
    OP_RD_BKT,
    OP_TAKE_BKT,
    OP_NEXT_BKT,
    OP_NODE_HASH,
    OP_RD_SPARE,
    OP_RELINK,
    OP_CP_RD,
    OP_CP_WR,
    OP_CLEAR,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cfg_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       cur_null;
    logic       key_match;
    logic       hash_done;
    logic       full;
    logic       fsp_nz;
    logic       grow;
    logic       shrink;
    logic       clr_last;
    logic       nb_last;
    logic       b_last;
  } dp_status_t;

endpackage

@@ hw/rtl/chm_hash.sv @@
// Bucket index unit: multiplicative hash or bit-serial key modulo.
module chm_hash #(
  parameter int MAX_BUCKETS = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 mode,
  input  logic [30:0]                          key,
  input  logic [$clog2(MAX_BUCKETS+1)-1:0]     nb,
  output logic                                 done,
  output logic [$clog2(MAX_BUCKETS)-1:0]       bucket
);

  localparam int BW  = $clog2(MAX_BUCKETS);
  localparam int BCW = $clog2(MAX_BUCKETS+1);

  chm_pkg::hash_st_t st_r, st_nxt;
  logic [30:0]    key_r, key_nxt;
  logic [BCW-1:0] nb_r, nb_nxt;
  logic [31:0]    frac_r, frac_nxt;
  logic [BCW-1:0] rem_r, rem_nxt;
  logic [4:0]     bit_r, bit_nxt;
  logic [BW-1:0]  bucket_r, bucket_nxt;
  logic           done_r, done_nxt;
  logic [BCW:0]   trial;
  logic [63:0]    prod;

  always_comb begin
    st_nxt     = st_r;
    key_nxt    = key_r;
    nb_nxt     = nb_r;
    frac_nxt   = frac_r;
    rem_nxt    = rem_r;
    bit_nxt    = bit_r;
    bucket_nxt = bucket_r;
    done_nxt   = 1'b0;
    trial      = {rem_r, key_r[bit_r]};
    prod       = 64'(frac_r) * 64'(nb_r);
    case (st_r)
      chm_pkg::HS_IDLE: begin
        if (start) begin
          key_nxt = key;
          nb_nxt  = nb;
          rem_nxt = '0;
          bit_nxt = 5'd30;
          st_nxt  = (mode == chm_pkg::HASH_MULT) ? chm_pkg::HS_MUL1 : chm_pkg::HS_DIV;
        end
      end
      chm_pkg::HS_MUL1: begin
        frac_nxt = 32'(64'(key_r) * 64'(chm_pkg::GOLDEN_Q32));
        st_nxt   = chm_pkg::HS_MUL2;
      end
      chm_pkg::HS_MUL2: begin
        bucket_nxt = BW'(prod >> 32);
        done_nxt   = 1'b1;
        st_nxt     = chm_pkg::HS_IDLE;
      end
      chm_pkg::HS_DIV: begin
        // restoring remainder, one key bit per cycle, msb first
        if (trial >= {1'b0, nb_r}) begin
          rem_nxt = BCW'(trial - {1'b0, nb_r});
        end else begin
          rem_nxt = BCW'(trial);
        end
        bit_nxt = bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          bucket_nxt = BW'(rem_nxt);
          done_nxt   = 1'b1;
          st_nxt     = chm_pkg::HS_IDLE;
        end
      end
      default: st_nxt = chm_pkg::HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= chm_pkg::HS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    key_r    <= key_nxt;
    nb_r     <= nb_nxt;
    frac_r   <= frac_nxt;
    rem_r    <= rem_nxt;
    bit_r    <= bit_nxt;
    bucket_r <= bucket_nxt;
  end

  assign done   = done_r;
  assign bucket = bucket_r;

endmodule

@@ hw/rtl/chm_datapath.sv @@
// Datapath: bucket and node memories, free list, counters and result register.
module chm_datapath #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_BUCKETS = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chm_pkg::dp_cmd_t    cmd,
  input  chm_pkg::in_item_t   in_data,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data,
  output chm_pkg::dp_status_t st,
  output chm_pkg::out_item_t  out_data
);

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int NW  = $clog2(MAX_ENTRIES+1);
  localparam int CW  = NW;
  localparam int BW  = $clog2(MAX_BUCKETS);
  localparam int BCW = $clog2(MAX_BUCKETS+1);
  localparam logic [NW-1:0] NODE_NONE = NW'(MAX_ENTRIES);

  logic [NW-1:0]  head_mem  [MAX_BUCKETS];
  logic [NW-1:0]  spare_mem [MAX_BUCKETS];
  logic [30:0]    key_mem   [MAX_ENTRIES];
  logic [31:0]    val_mem   [MAX_ENTRIES];
  logic [NW-1:0]  link_mem  [MAX_ENTRIES];
  logic [IW-1:0]  free_mem  [MAX_ENTRIES];

  logic [NW-1:0]  head_rd_r, spare_rd_r, link_rd_r;
  logic [30:0]    key_rd_r;
  logic [31:0]    val_rd_r;
  logic [IW-1:0]  free_rd_r;

  logic           hmode_r, hmode_nxt;
  logic [8:0]     init_r, init_nxt;
  logic [BCW-1:0] buckets_r, buckets_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  fresh_r, fresh_nxt;
  logic [CW-1:0]  fsp_r, fsp_nxt;
  logic [BCW-1:0] idx_r, idx_nxt;
  logic [BCW-1:0] nb_r, nb_nxt;
  logic [1:0]     kind_r, kind_nxt;
  logic [30:0]    key_r, key_nxt;
  logic [31:0]    val_r, val_nxt;
  logic [NW-1:0]  cur_r, cur_nxt;
  logic [NW-1:0]  prev_r, prev_nxt;
  logic [NW-1:0]  head_r, head_nxt;
  logic [NW-1:0]  next_r, next_nxt;
  logic           found_r, found_nxt;
  logic [31:0]    vout_r, vout_nxt;
  logic           status_r, status_nxt;
  chm_pkg::out_item_t out_r, out_nxt;

  logic           head_we, spare_we, key_we, val_we, link_we, free_we;
  logic [BW-1:0]  head_wa, spare_wa, head_ra, spare_ra;
  logic [NW-1:0]  head_wd, spare_wd, link_wd;
  logic [IW-1:0]  node_wa, link_wa, free_wa;
  logic [CW-1:0]  fsp_m1;
  logic [NW-1:0]  new_node;
  logic [8:0]     init_sel;
  logic [31:0]    init_ext;

  logic           hstart;
  logic [30:0]    hkey;
  logic [BCW-1:0] hnb;
  logic           hdone;
  logic [BW-1:0]  bucket;
  logic           over;

  chm_hash #(.MAX_BUCKETS(MAX_BUCKETS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hstart),
    .mode   (hmode_r),
    .key    (hkey),
    .nb     (hnb),
    .done   (hdone),
    .bucket (bucket)
  );

  assign fsp_m1   = fsp_r - CW'(1);
  assign new_node = (fsp_r != '0) ? NW'(free_rd_r) : NW'(fresh_r);
  assign head_ra  = (cmd.op == chm_pkg::OP_RD_HEAD)  ? bucket : idx_r[BW-1:0];
  assign spare_ra = (cmd.op == chm_pkg::OP_RD_SPARE) ? bucket : idx_r[BW-1:0];
  assign over     = 32'(count_r) > 32'(buckets_r);

  always_comb begin
    st.kind      = kind_r;
    st.cur_null  = (cur_r == NODE_NONE);
    st.key_match = (key_rd_r == key_r);
    st.hash_done = hdone;
    st.full      = (32'(count_r) >= 32'(MAX_ENTRIES));
    st.fsp_nz    = (fsp_r != '0);
    st.grow      = over && ((32'(buckets_r) << 1) <= 32'(MAX_BUCKETS));
    st.shrink    = !over && ((32'(count_r) << 2) < 32'(buckets_r))
                   && (32'(buckets_r) > 32'd2);
    st.clr_last  = (32'(idx_r) == 32'(MAX_BUCKETS - 1));
    st.nb_last   = (idx_r == nb_r - BCW'(1));
    st.b_last    = (idx_r == buckets_r - BCW'(1));
  end

  always_comb begin
    hmode_nxt   = hmode_r;
    init_nxt    = init_r;
    buckets_nxt = buckets_r;
    count_nxt   = count_r;
    fresh_nxt   = fresh_r;
    fsp_nxt     = fsp_r;
    idx_nxt     = idx_r;
    nb_nxt      = nb_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    head_nxt    = head_r;
    next_nxt    = next_r;
    found_nxt   = found_r;
    vout_nxt    = vout_r;
    status_nxt  = status_r;
    out_nxt     = out_r;
    head_we  = 1'b0; head_wa  = idx_r[BW-1:0]; head_wd  = NODE_NONE;
    spare_we = 1'b0; spare_wa = idx_r[BW-1:0]; spare_wd = NODE_NONE;
    key_we   = 1'b0; val_we   = 1'b0; node_wa = cur_r[IW-1:0];
    link_we  = 1'b0; link_wa  = cur_r[IW-1:0]; link_wd  = NODE_NONE;
    free_we  = 1'b0; free_wa  = fsp_r[IW-1:0];
    hstart   = 1'b0;
    hkey     = key_r;
    hnb      = buckets_r;
    init_sel = init_r;
    init_ext = '0;

    if (cmd.cfg_wr) begin
      // any register write clears the store
      if (cfg_index == chm_pkg::CFG_HASH_MODE) begin
        hmode_nxt = cfg_data[0];
      end else begin
        init_nxt = cfg_data;
        init_sel = cfg_data;
      end
      init_ext = 32'(init_sel);
      if (init_ext == 32'd0) begin
        buckets_nxt = BCW'(1);
      end else if (init_ext > 32'(MAX_BUCKETS)) begin
        buckets_nxt = BCW'(MAX_BUCKETS);
      end else begin
        buckets_nxt = BCW'(init_ext);
      end
      count_nxt = '0;
      fresh_nxt = '0;
      fsp_nxt   = '0;
      idx_nxt   = '0;
    end else begin
      case (cmd.op)
        chm_pkg::OP_LOAD: begin
          kind_nxt   = in_data.kind;
          key_nxt    = in_data.key;
          val_nxt    = in_data.value;
          found_nxt  = 1'b0;
          vout_nxt   = '0;
          status_nxt = 1'b0;
        end
        chm_pkg::OP_HASH_ITEM: hstart = 1'b1;
        chm_pkg::OP_TAKE_HEAD: begin
          cur_nxt  = head_rd_r;
          head_nxt = head_rd_r;
          prev_nxt = NODE_NONE;
        end
        chm_pkg::OP_STEP: begin
          prev_nxt = cur_r;
          cur_nxt  = link_rd_r;
        end
        chm_pkg::OP_UPDATE: begin
          val_we    = 1'b1;
          found_nxt = 1'b1;
        end
        chm_pkg::OP_TAKE_VAL: begin
          vout_nxt  = val_rd_r;
          found_nxt = 1'b1;
        end
        chm_pkg::OP_UNLINK: begin
          if (prev_r == NODE_NONE) begin
            head_we = 1'b1;
            head_wa = bucket;
            head_wd = link_rd_r;
          end else begin
            link_we = 1'b1;
            link_wa = prev_r[IW-1:0];
            link_wd = link_rd_r;
          end
          free_we   = 1'b1;
          fsp_nxt   = fsp_r + CW'(1);
          count_nxt = count_r - CW'(1);
          found_nxt = 1'b1;
        end
        chm_pkg::OP_FULL: status_nxt = 1'b1;
        chm_pkg::OP_ALLOC: begin
          // new node goes to the head of its chain
          node_wa = new_node[IW-1:0];
          key_we  = 1'b1;
          val_we  = 1'b1;
          link_we = 1'b1;
          link_wa = new_node[IW-1:0];
          link_wd = head_r;
          head_we = 1'b1;
          head_wa = bucket;
          head_wd = new_node;
          if (fsp_r != '0) begin
            fsp_nxt = fsp_m1;
          end else begin
            fresh_nxt = fresh_r + CW'(1);
          end
          count_nxt = count_r + CW'(1);
        end
        chm_pkg::OP_GROW: begin
          nb_nxt  = BCW'(buckets_r << 1);
          idx_nxt = '0;
        end
        chm_pkg::OP_SHRINK: begin
          nb_nxt  = buckets_r >> 1;
          idx_nxt = '0;
        end
        chm_pkg::OP_CLR_SPARE: begin
          spare_we = 1'b1;
          idx_nxt  = st.nb_last ? '0 : idx_r + BCW'(1);
        end
        chm_pkg::OP_TAKE_BKT: cur_nxt = head_rd_r;
        chm_pkg::OP_NEXT_BKT: idx_nxt = st.b_last ? '0 : idx_r + BCW'(1);
        chm_pkg::OP_NODE_HASH: begin
          next_nxt = link_rd_r;
          hstart   = 1'b1;
          hkey     = key_rd_r;
          hnb      = nb_r;
        end
        chm_pkg::OP_RELINK: begin
          link_we  = 1'b1;
          link_wd  = spare_rd_r;
          spare_we = 1'b1;
          spare_wa = bucket;
          spare_wd = cur_r;
          cur_nxt  = next_r;
        end
        chm_pkg::OP_CP_WR: begin
          head_we = 1'b1;
          head_wd = spare_rd_r;
          if (st.nb_last) begin
            idx_nxt     = '0;
            buckets_nxt = nb_r;
          end else begin
            idx_nxt = idx_r + BCW'(1);
          end
        end
        chm_pkg::OP_CLEAR: begin
          head_we = 1'b1;
          idx_nxt = st.clr_last ? '0 : idx_r + BCW'(1);
        end
        chm_pkg::OP_FINISH: begin
          out_nxt.found        = found_r;
          out_nxt.value_out    = vout_r;
          out_nxt.status       = status_r;
          out_nxt.entry_count  = 9'(count_r);
          out_nxt.bucket_count = 9'(buckets_r);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (spare_we) spare_mem[spare_wa] <= spare_wd;
    spare_rd_r <= spare_mem[spare_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[node_wa] <= key_r;
    key_rd_r <= key_mem[cur_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[node_wa] <= val_r;
    val_rd_r <= val_mem[cur_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_r <= link_mem[cur_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= cur_r[IW-1:0];
    free_rd_r <= free_mem[fsp_m1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmode_r   <= 1'b0;
      init_r    <= 9'd4;
      buckets_r <= BCW'(4);
      count_r   <= '0;
      fresh_r   <= '0;
      fsp_r     <= '0;
      idx_r     <= '0;
    end else begin
      hmode_r   <= hmode_nxt;
      init_r    <= init_nxt;
      buckets_r <= buckets_nxt;
      count_r   <= count_nxt;
      fresh_r   <= fresh_nxt;
      fsp_r     <= fsp_nxt;
      idx_r     <= idx_nxt;
    end
    nb_r     <= nb_nxt;
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    head_r   <= head_nxt;
    next_r   <= next_nxt;
    found_r  <= found_nxt;
    vout_r   <= vout_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign out_data = out_r;

endmodule

@@ hw/rtl/chm_ctrl.sv @@
// Controller: sequences lookup, update, removal, allocation, rehash and clearing.
module chm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  chm_pkg::dp_status_t st,
  output chm_pkg::dp_cmd_t    cmd
);

  chm_pkg::ctrl_st_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign cfg_ready = (state_r == chm_pkg::ST_IDLE) || (state_r == chm_pkg::ST_CLEAR);
  assign in_stall  = (state_r != chm_pkg::ST_IDLE) || cfg_valid;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = chm_pkg::OP_NONE;
    cmd.cfg_wr = cfg_valid && cfg_ready;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    case (state_r)
      chm_pkg::ST_CLEAR: begin
        if (!cmd.cfg_wr) begin
          cmd.op = chm_pkg::OP_CLEAR;
          if (st.clr_last) state_nxt = chm_pkg::ST_IDLE;
        end
      end
      chm_pkg::ST_IDLE: begin
        if (cmd.cfg_wr) begin
          state_nxt = chm_pkg::ST_CLEAR;
        end else if (in_valid) begin
          cmd.op    = chm_pkg::OP_LOAD;
          state_nxt = chm_pkg::ST_HSTART;
        end
      end
      chm_pkg::ST_HSTART: begin
        if (st.kind == chm_pkg::KIND_NONE) begin
          state_nxt = chm_pkg::ST_FIN;
        end else begin
          cmd.op    = chm_pkg::OP_HASH_ITEM;
          state_nxt = chm_pkg::ST_HWAIT;
        end
      end
      chm_pkg::ST_HWAIT: begin
        if (st.hash_done) begin
          cmd.op    = chm_pkg::OP_RD_HEAD;
          state_nxt = chm_pkg::ST_TAKEHEAD;
        end
      end
      chm_pkg::ST_TAKEHEAD: begin
        cmd.op    = chm_pkg::OP_TAKE_HEAD;
        state_nxt = chm_pkg::ST_WALK;
      end
      chm_pkg::ST_WALK: begin
        if (!st.cur_null) begin
          cmd.op    = chm_pkg::OP_RD_NODE;
          state_nxt = chm_pkg::ST_CMP;
        end else if (st.kind == chm_pkg::KIND_INSERT) begin
          if (st.full) begin
            cmd.op    = chm_pkg::OP_FULL;
            state_nxt = chm_pkg::ST_FIN;
          end else if (st.fsp_nz) begin
            cmd.op    = chm_pkg::OP_RD_FREE;
            state_nxt = chm_pkg::ST_POP;
          end else begin
            cmd.op    = chm_pkg::OP_ALLOC;
            state_nxt = chm_pkg::ST_RSCHK;
          end
        end else begin
          state_nxt = chm_pkg::ST_FIN;
        end
      end
      chm_pkg::ST_CMP: begin
        if (!st.key_match) begin
          cmd.op    = chm_pkg::OP_STEP;
          state_nxt = chm_pkg::ST_WALK;
        end else if (st.kind == chm_pkg::KIND_INSERT) begin
          cmd.op    = chm_pkg::OP_UPDATE;
          state_nxt = chm_pkg::ST_FIN;
        end else if (st.kind == chm_pkg::KIND_REMOVE) begin
          cmd.op    = chm_pkg::OP_UNLINK;
          state_nxt = chm_pkg::ST_RSCHK;
        end else begin
          cmd.op    = chm_pkg::OP_RD_VAL;
          state_nxt = chm_pkg::ST_TAKEVAL;
        end
      end
      chm_pkg::ST_TAKEVAL: begin
        cmd.op    = chm_pkg::OP_TAKE_VAL;
        state_nxt = chm_pkg::ST_FIN;
      end
      chm_pkg::ST_POP: begin
        cmd.op    = chm_pkg::OP_ALLOC;
        state_nxt = chm_pkg::ST_RSCHK;
      end
      chm_pkg::ST_RSCHK: begin
        if (st.grow) begin
          cmd.op    = chm_pkg::OP_GROW;
          state_nxt = chm_pkg::ST_RCLR;
        end else if (st.shrink) begin
          cmd.op    = chm_pkg::OP_SHRINK;
          state_nxt = chm_pkg::ST_RCLR;
        end else begin
          state_nxt = chm_pkg::ST_FIN;
        end
      end
      chm_pkg::ST_RCLR: begin
        cmd.op = chm_pkg::OP_CLR_SPARE;
        if (st.nb_last) state_nxt = chm_pkg::ST_RBKT;
      end
      chm_pkg::ST_RBKT: begin
        cmd.op    = chm_pkg::OP_RD_BKT;
        state_nxt = chm_pkg::ST_RTAKE;
      end
      chm_pkg::ST_RTAKE: begin
        cmd.op    = chm_pkg::OP_TAKE_BKT;
        state_nxt = chm_pkg::ST_RNODE;
      end
      chm_pkg::ST_RNODE: begin
        if (st.cur_null) begin
          cmd.op    = chm_pkg::OP_NEXT_BKT;
          state_nxt = st.b_last ? chm_pkg::ST_RCPR : chm_pkg::ST_RBKT;
        end else begin
          cmd.op    = chm_pkg::OP_RD_NODE;
          state_nxt = chm_pkg::ST_RKEY;
        end
      end
      chm_pkg::ST_RKEY: begin
        cmd.op    = chm_pkg::OP_NODE_HASH;
        state_nxt = chm_pkg::ST_RHW;
      end
      chm_pkg::ST_RHW: begin
        if (st.hash_done) begin
          cmd.op    = chm_pkg::OP_RD_SPARE;
          state_nxt = chm_pkg::ST_RRELINK;
        end
      end
      chm_pkg::ST_RRELINK: begin
        cmd.op    = chm_pkg::OP_RELINK;
        state_nxt = chm_pkg::ST_RNODE;
      end
      chm_pkg::ST_RCPR: begin
        cmd.op    = chm_pkg::OP_CP_RD;
        state_nxt = chm_pkg::ST_RCPW;
      end
      chm_pkg::ST_RCPW: begin
        cmd.op    = chm_pkg::OP_CP_WR;
        state_nxt = st.nb_last ? chm_pkg::ST_FIN : chm_pkg::ST_RCPR;
      end
      chm_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.op        = chm_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = chm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chm_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chm_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/chained_hash_map.sv @@
// Top level of the chained hash map: controller, datapath and checks.
// Usage:
//   in channel (in_valid/in_stall/in_data) carries one operation per transaction:
//   insert/update, remove or search. One operation is in flight at a time.
//   out channel (out_valid/out_stall/out_data) returns one result per operation
//   from an output register; the next operation is taken while it waits.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes hash_mode or
//   initial_buckets; every write empties the map.
// Steps: hash the key, read the bucket head, then visit the chain node by node;
//   a search hit, a free-list pop or a resize check add a step each. The
//   key-modulo hash takes one key bit per cycle in the hash unit.
// Issue: the next operation can be taken the cycle after a result is
//   registered, unless a register write is accepted first.
// A resize clears the spare heads, walks every old chain rehashing each node
//   into a spare head, then copies the spare heads back to the bucket heads.
// Reset and each register write run a clearing pass over all MAX_BUCKETS
//   bucket heads; in_stall stays high during it.
// If the receiver stalls, a finished result is held and the block waits
//   before delivering the following one.
module chained_hash_map #(
  parameter int MAX_ENTRIES = 256,
  parameter int MAX_BUCKETS = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output chm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);

  chm_pkg::dp_cmd_t    cmd;
  chm_pkg::dp_status_t st;

  chm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  chm_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .st        (st),
    .out_data  (out_data)
  );

  // one operation at a time
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an operation is in flight");

  // a register write starts the clearing pass
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input open right after a register write");

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input open right after reset");

endmodule

@@ sim/chained_hash_map_tb.sv @@
// Self-checking testbench for the chained hash map: directed table, then random operations and a pool fill.
module chained_hash_map_tb;

  localparam int POOL_SIZE     = 256;
  localparam int BUCKET_LIMIT  = 512;
  localparam int STALL_LIMIT   = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  chm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  chm_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [8:0]         cfg_data = '0;

  chained_hash_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the map contents; chain layout never shows at the outputs
  logic [31:0]        shadow_map [logic [30:0]];
  int                 shadow_buckets;
  logic [8:0]         init_reg;
  chm_pkg::out_item_t expected_q[$];
  int                 mismatches = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;
  logic [30:0]        key_salt = '0;
  int                 key_span = 48;

  typedef struct {
    logic [1:0]         kind;
    logic [30:0]        key;
    logic [31:0]        value;
    bit                 typed;
    chm_pkg::out_item_t result;
  } row_t;

  function automatic chm_pkg::out_item_t mk(bit f, logic [31:0] v, bit s, int c, int b);
    chm_pkg::out_item_t r;
    r.found = f;
    r.value_out = v;
    r.status = s;
    r.entry_count = c[8:0];
    r.bucket_count = b[8:0];
    return r;
  endfunction

  function automatic void clear_shadow();
    shadow_map.delete();
    shadow_buckets = (init_reg == 0) ? 1 : init_reg;
    if (shadow_buckets > BUCKET_LIMIT) shadow_buckets = BUCKET_LIMIT;
  endfunction

  function automatic void rebalance();
    int n;
    n = shadow_map.size();
    if (n > shadow_buckets) begin
      if (2 * shadow_buckets <= BUCKET_LIMIT) shadow_buckets = 2 * shadow_buckets;
    end else if (4 * n < shadow_buckets && shadow_buckets > 2) begin
      shadow_buckets = shadow_buckets / 2;
    end
  endfunction

  function automatic chm_pkg::out_item_t apply_op(chm_pkg::in_item_t it);
    bit          hit;
    logic [31:0] vout;
    bit          full;
    hit = shadow_map.exists(it.key);
    vout = '0;
    full = 1'b0;
    case (it.kind)
      chm_pkg::KIND_INSERT: begin
        if (hit) begin
          shadow_map[it.key] = it.value;
        end else if (shadow_map.size() >= POOL_SIZE) begin
          full = 1'b1;
        end else begin
          shadow_map[it.key] = it.value;
          rebalance();
        end
      end
      chm_pkg::KIND_REMOVE: begin
        if (hit) begin
          shadow_map.delete(it.key);
          rebalance();
        end
      end
      chm_pkg::KIND_SEARCH: if (hit) vout = shadow_map[it.key];
      default: hit = 1'b0;
    endcase
    if (it.kind == chm_pkg::KIND_NONE) hit = 1'b0;
    return mk(hit && it.kind != chm_pkg::KIND_NONE, vout, full, shadow_map.size(),
              shadow_buckets);
  endfunction

  task automatic send_op(logic [1:0] kind, logic [30:0] key, logic [31:0] value,
                         bit typed, chm_pkg::out_item_t typed_res);
    chm_pkg::in_item_t  it;
    chm_pkg::out_item_t pred;
    it.kind = kind;
    it.key = key;
    it.value = value;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pred = apply_op(it);
    expected_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == chm_pkg::CFG_INIT_BUCKETS) init_reg = data;
    clear_shadow();
  endtask

  function automatic logic [30:0] pick_key();
    if ($urandom_range(99) < 20) return 31'($urandom);
    return key_salt ^ 31'($urandom_range(key_span - 1));
  endfunction

  task automatic random_ops(int count);
    int          r;
    logic [1:0]  k;
    repeat (count) begin
      r = $urandom_range(99);
      k = (r < 45) ? chm_pkg::KIND_INSERT : (r < 70) ? chm_pkg::KIND_REMOVE :
          (r < 95) ? chm_pkg::KIND_SEARCH : chm_pkg::KIND_NONE;
      send_op(k, pick_key(), $urandom, 1'b0, '0);
    end
  endtask

  // fills the pool to the brim, probes the full case, then empties it again
  task automatic fill_and_empty(logic [30:0] stride);
    for (int i = 0; i < POOL_SIZE + 3; i++)
      send_op(chm_pkg::KIND_INSERT, key_salt ^ 31'(stride * i), $urandom, 1'b0, '0);
    send_op(chm_pkg::KIND_SEARCH, key_salt ^ 31'(stride * 7), '0, 1'b0, '0);
    for (int i = 0; i < POOL_SIZE + 1; i++)
      send_op(chm_pkg::KIND_REMOVE, key_salt ^ 31'(stride * i), $urandom, 1'b0, '0);
  endtask

  row_t directed[] = '{
    '{chm_pkg::KIND_SEARCH, 31'd0,        32'd0,        1'b1,
      mk(1'b0, 0, 1'b0, 0, 4)},
    '{chm_pkg::KIND_INSERT, 31'd0,        32'h7fffffff, 1'b1,
      mk(1'b0, 0, 1'b0, 1, 4)},
    '{chm_pkg::KIND_INSERT, 31'h7fffffff, 32'h80000000, 1'b1,
      mk(1'b0, 0, 1'b0, 2, 4)},
    '{chm_pkg::KIND_SEARCH, 31'h7fffffff, 32'h12345678, 1'b1,
      mk(1'b1, 32'h80000000, 1'b0, 2, 4)},
    '{chm_pkg::KIND_INSERT, 31'd0,        32'hffffffff, 1'b1,
      mk(1'b1, 0, 1'b0, 2, 4)},
    '{chm_pkg::KIND_SEARCH, 31'd0,        32'd0,        1'b1,
      mk(1'b1, 32'hffffffff, 1'b0, 2, 4)},
    '{chm_pkg::KIND_NONE,   31'd5,        32'hdeadbeef, 1'b1,
      mk(1'b0, 0, 1'b0, 2, 4)},
    '{chm_pkg::KIND_REMOVE, 31'd3,        32'd0,        1'b1,
      mk(1'b0, 0, 1'b0, 2, 4)},
    '{chm_pkg::KIND_INSERT, 31'd1,        32'd11,       1'b0, '0},
    '{chm_pkg::KIND_INSERT, 31'd2,        32'd22,       1'b0, '0},
    '{chm_pkg::KIND_INSERT, 31'd3,        32'd33,       1'b0, '0},
    '{chm_pkg::KIND_INSERT, 31'h55555555, 32'h55555555, 1'b0, '0},
    '{chm_pkg::KIND_INSERT, 31'h2aaaaaaa, 32'haaaaaaaa, 1'b0, '0},
    '{chm_pkg::KIND_SEARCH, 31'd2,        32'd0,        1'b0, '0},
    '{chm_pkg::KIND_REMOVE, 31'h7fffffff, 32'd0,        1'b0, '0},
    '{chm_pkg::KIND_REMOVE, 31'd1,        32'd0,        1'b0, '0},
    '{chm_pkg::KIND_REMOVE, 31'd2,        32'd0,        1'b0, '0},
    '{chm_pkg::KIND_REMOVE, 31'h55555555, 32'd0,        1'b0, '0},
    '{chm_pkg::KIND_REMOVE, 31'h2aaaaaaa, 32'd0,        1'b0, '0},
    '{chm_pkg::KIND_REMOVE, 31'd0,        32'd0,        1'b0, '0},
    '{chm_pkg::KIND_SEARCH, 31'd3,        32'd0,        1'b0, '0},
    '{chm_pkg::KIND_REMOVE, 31'd3,        32'd0,        1'b0, '0}
  };

  // result checker; stall is sampled before this edge's update
  always @(posedge clk) begin
    chm_pkg::out_item_t want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    init_reg = 9'd4;
    clear_shadow();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_op(directed[i].kind, directed[i].key, directed[i].value,
              directed[i].typed, directed[i].result);
    random_ops(60);
    drain();

    // no idling, smallest table, key modulo
    write_reg(chm_pkg::CFG_HASH_MODE, 9'(chm_pkg::HASH_MOD));
    write_reg(chm_pkg::CFG_INIT_BUCKETS, 9'd0);
    key_salt = 31'($urandom);
    random_ops(80);
    drain();

    // sender idles half the time, pool filled in multiplicative mode
    idle_pct = 50;
    write_reg(chm_pkg::CFG_HASH_MODE, 9'(chm_pkg::HASH_MULT));
    write_reg(chm_pkg::CFG_INIT_BUCKETS, 9'd1);
    key_salt = 31'($urandom);
    fill_and_empty(31'd977);
    random_ops(60);
    drain();

    // receiver stalls half the time, widest table
    idle_pct = 0;
    stall_pct = 50;
    write_reg(chm_pkg::CFG_INIT_BUCKETS, 9'd511);
    key_salt = 31'($urandom);
    key_span = 300;
    random_ops(200);
    drain();

    // both sides idle, key modulo on a mid-size table
    idle_pct = 31;
    stall_pct = 31;
    write_reg(chm_pkg::CFG_HASH_MODE, 9'(chm_pkg::HASH_MOD));
    write_reg(chm_pkg::CFG_INIT_BUCKETS, 9'd256);
    key_salt = 31'($urandom);
    key_span = 24;
    random_ops(200);
    drain();

    idle_pct = 0;
    stall_pct = 0;
    write_reg(chm_pkg::CFG_INIT_BUCKETS, 9'd3);
    key_salt = 31'($urandom);
    random_ops(20);
    drain();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ chained_hash_map.f @@
hw/rtl/chm_pkg.sv
hw/rtl/chm_hash.sv
hw/rtl/chm_datapath.sv
hw/rtl/chm_ctrl.sv
hw/rtl/chained_hash_map.sv
sim/chained_hash_map_tb.sv
